>>> sv/ppd_pkg.sv
package ppd_pkg;

    localparam int unsigned SAMPLE_W = 10;
    localparam int unsigned GAIN_W   = 10;
    localparam int unsigned FALL_W   = 12;
    localparam int unsigned CFG_W    = 12;
    // scaled value: 1023 * 1023 fits in 20 bits
    localparam int unsigned VAL_W    = SAMPLE_W + GAIN_W;
    // value plus a margin
    localparam int unsigned SUM_W    = VAL_W + 1;
    // signed peak level, range -1023 .. 1046529
    localparam int unsigned PEAK_W   = VAL_W + 1;
    // common signed width for compares
    localparam int unsigned CMP_W    = VAL_W + 3;

    // floor(4v/5) == (v * RECIP5) >> RECIP_SHIFT for v below 2^22
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP5 = 24'd13421773;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd50;
    localparam logic [FALL_W-1:0] FALL_RESET = 12'd150;

    typedef enum logic [0:0] {
        REG_GAIN        = 1'b0,
        REG_FALL_MARGIN = 1'b1
    } t_reg_idx;

endpackage

>>> sv/pulse_peak_detector.sv
// Pulse peak detector: each accepted 10-bit sample yields one beat word, 1 on
// the first sample of a new heartbeat peak. The sample is scaled by the gain
// register and compared against a tracked peak with hysteresis (rise margin =
// gain, fall margin = fall_margin). One sample is accepted every clock while the
// result slot is free or being taken; a word passes four register stages (input,
// multiply, divide-by-5 and margins, peak update and result) before o_out_valid rises.
// The whole pipeline advances together and holds while the result is not
// taken. Only the last stage carries the peak state, so consecutive samples
// never wait on one another. Registers are written through the plain write port;
// the user must write only while the block is idle (unenforced); index 0 is gain, index 1 is fall_margin.
module pulse_peak_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ppd_pkg::SAMPLE_W-1:0] i_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_beat,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [ppd_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int unsigned PROD_W = ppd_pkg::VAL_W + ppd_pkg::RECIP_W;

    logic [ppd_pkg::GAIN_W-1:0]   r_gain;
    logic [ppd_pkg::FALL_W-1:0]   r_fall;

    logic                         r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    logic [ppd_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic [ppd_pkg::VAL_W-1:0]    r_s2_v;
    logic [ppd_pkg::VAL_W-1:0]    r_s3_v;
    logic [ppd_pkg::VAL_W-1:0]    r_s3_q;
    logic [ppd_pkg::SUM_W-1:0]    r_s3_vg;
    logic [ppd_pkg::SUM_W-1:0]    r_s3_vfm;
    logic                         r_beat;

    logic signed [ppd_pkg::PEAK_W-1:0] r_peak, n_peak;
    logic                              r_in_peak, n_in_peak;
    logic                              n_beat;

    logic                         advance;
    logic [PROD_W-1:0]            prod;

    logic signed [ppd_pkg::CMP_W-1:0] p_ext, v4_ext, q_ext, v_ext, vg_ext, vfm_ext;
    logic signed [ppd_pkg::CMP_W-1:0] g_ext, p_rst, p_upd;
    logic                             rise, fall;

    // whole pipeline moves when the result slot is free or being taken
    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = advance;
    assign o_out_valid = r_out_valid;
    assign o_beat      = r_beat;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= ppd_pkg::GAIN_RESET;
            r_fall <= ppd_pkg::FALL_RESET;
        end else if (i_cfg_we) begin
            case (ppd_pkg::t_reg_idx'(i_cfg_idx))
                ppd_pkg::REG_GAIN:        r_gain <= i_cfg_data[ppd_pkg::GAIN_W-1:0];
                ppd_pkg::REG_FALL_MARGIN: r_fall <= i_cfg_data[ppd_pkg::FALL_W-1:0];
                default: ;
            endcase
        end
    end

    // floor(4v/5) by reciprocal multiply
    assign prod = PROD_W'(r_s2_v) * PROD_W'(ppd_pkg::RECIP5);

    // peak update
    always_comb begin
        p_ext   = ppd_pkg::CMP_W'(r_peak);
        v_ext   = $signed({3'b000, r_s3_v});
        v4_ext  = $signed({1'b0, r_s3_v, 2'b00});
        q_ext   = $signed({3'b000, r_s3_q});
        vg_ext  = $signed({2'b00, r_s3_vg});
        vfm_ext = $signed({2'b00, r_s3_vfm});
        g_ext   = $signed({{(ppd_pkg::CMP_W - ppd_pkg::GAIN_W){1'b0}}, r_gain});

        // sensor restart when value drops under a quarter of the peak
        p_rst = (v4_ext < p_ext) ? q_ext : p_ext;
        // v > p - g  and  v < p - fall written without subtraction
        rise  = vg_ext > p_rst;
        fall  = vfm_ext < p_rst;

        n_in_peak = r_in_peak;
        n_beat    = 1'b0;
        p_upd     = p_rst;
        if (rise) begin
            if (v_ext > p_rst) begin
                p_upd = v_ext;
            end
            n_beat    = !r_in_peak;
            n_in_peak = 1'b1;
        end else if (fall) begin
            n_in_peak = 1'b0;
            p_upd     = p_rst - g_ext;
        end
        n_peak = p_upd[ppd_pkg::PEAK_W-1:0];
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_in_peak   <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            if (r_s3_valid) begin
                r_peak    <= n_peak;
                r_in_peak <= n_in_peak;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_sample <= i_sample;
            r_s2_v      <= ppd_pkg::VAL_W'(r_s1_sample) * ppd_pkg::VAL_W'(r_gain);
            r_s3_v      <= r_s2_v;
            r_s3_q      <= prod[ppd_pkg::RECIP_SHIFT +: ppd_pkg::VAL_W];
            r_s3_vg     <= ppd_pkg::SUM_W'(r_s2_v) + ppd_pkg::SUM_W'(r_gain);
            r_s3_vfm    <= ppd_pkg::SUM_W'(r_s2_v) + ppd_pkg::SUM_W'(r_fall);
            r_beat      <= n_beat;
        end
    end

    // a reported beat always leaves the block inside a peak
    a_beat_in_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_beat |-> r_in_peak)
        else $error("beat reported while not in peak");

    // peak never decays below one gain step under zero
    a_peak_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= -$signed(ppd_pkg::PEAK_W'(1023)))
        else $error("peak level below lower bound");

    // peak never exceeds the largest scaled value
    a_peak_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak <= $signed(ppd_pkg::PEAK_W'(1046529)))
        else $error("peak level above upper bound");

    // a stalled pipeline leaves the peak state untouched
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_peak) && $stable(r_in_peak))
        else $error("peak state changed during stall");

endmodule

>>> tb/tb_pulse_peak_detector.sv
`timescale 1ns / 100ps

module tb_pulse_peak_detector;

    localparam int unsigned CLK_HALF    = 5;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PIPE_DRAIN  = 8;
    localparam int unsigned PHASE_WORDS = 120;
    localparam int unsigned N_PHASES    = 8;

    // models the tracked peak and in-peak flag, queues one beat per sample
    class beat_scoreboard;
        logic [ppd_pkg::GAIN_W-1:0] gain;
        logic [ppd_pkg::FALL_W-1:0] fall_margin;
        longint            peak;
        bit                in_peak;
        bit                beat_q[$];
        int                n_errors;
        int                n_checked;
        int                n_beats;

        function new();
            gain        = ppd_pkg::GAIN_RESET;
            fall_margin = ppd_pkg::FALL_RESET;
            peak        = 0;
            in_peak     = 0;
            n_errors    = 0;
            n_checked   = 0;
            n_beats     = 0;
        endfunction

        function void set_reg(ppd_pkg::t_reg_idx idx, logic [ppd_pkg::CFG_W-1:0] data);
            case (idx)
                ppd_pkg::REG_GAIN: begin
                    gain = data[ppd_pkg::GAIN_W-1:0];
                end
                ppd_pkg::REG_FALL_MARGIN: begin
                    fall_margin = data[ppd_pkg::FALL_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void note_sample(logic [ppd_pkg::SAMPLE_W-1:0] s);
            longint g;
            longint v;
            longint p;
            bit     beat;
            g    = longint'(gain);
            v    = longint'(s) * g;
            p    = peak;
            beat = 0;
            // restart first, the rise test then sees the restarted peak
            if (v * 4 < p) begin
                p = (v * 4) / 5;
            end
            if (v > p - g) begin
                if (v > p) begin
                    p = v;
                end
                if (!in_peak) begin
                    beat = 1;
                end
                in_peak = 1;
            end else if (v < p - longint'(fall_margin)) begin
                in_peak = 0;
                p       = p - g;
            end
            peak = p;
            beat_q.push_back(beat);
        endfunction

        function void check_beat(logic b);
            bit want;
            if (beat_q.size() == 0) begin
                $display("%0t: unexpected beat word, expected none, got %0b", $time, b);
                n_errors++;
            end else begin
                want = beat_q.pop_front();
                n_checked++;
                if (want) begin
                    n_beats++;
                end
                if (b !== want) begin
                    $display("%0t: beat mismatch, expected %0b, got %0b", $time, want, b);
                    n_errors++;
                end
            end
        endfunction

        function int pending();
            return beat_q.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic [ppd_pkg::SAMPLE_W-1:0] i_sample;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic                         o_beat;
    logic                         i_cfg_we;
    logic [0:0]                   i_cfg_idx;
    logic [ppd_pkg::CFG_W-1:0]    i_cfg_data;

    pulse_peak_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_beat      (o_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    beat_scoreboard sb;
    int             n_sent;
    int             n_settings;
    int             burst_left;
    bit             gaps_on;
    int             rx_mode;
    bit             hold_req;
    int             n_holds;
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #CLK_HALF i_clk = ~i_clk;
    end

    // receiver: stall pattern per phase, plus a long hold-off on request
    initial begin
        int rx_tick;
        rx_tick     = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 0;
                n_holds++;
            end else begin
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 9) < 7);
                    2: i_out_ready <= ((rx_tick % 7) < 4);
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            rx_tick++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_beat(o_beat);
        end
    end

    // watchdog on cycles without any handshake or register write
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
            || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("pulse_peak_detector verification failed");
                $finish;
            end
        end
    end

    function automatic logic [ppd_pkg::SAMPLE_W-1:0] clip_sample(int s);
        if (s < 0) begin
            return '0;
        end
        if (s > 1023) begin
            return 10'd1023;
        end
        return s[ppd_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic [ppd_pkg::SAMPLE_W-1:0] s);
        if (burst_left == 0) begin
            if (gaps_on) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sb.note_sample(s);
        n_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input ppd_pkg::t_reg_idx idx,
                             input logic [ppd_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // gain field is 10 bits, the spare data bits get random junk
    task automatic load_setting(input int g, input int f);
        logic [ppd_pkg::CFG_W-1:0] d;
        d = {2'($urandom), 10'(g)};
        write_reg(ppd_pkg::REG_GAIN, d);
        write_reg(ppd_pkg::REG_FALL_MARGIN, 12'(f));
        n_settings++;
    endtask

    // one heartbeat shape: ramp up, ramp down, noisy baseline
    task automatic send_pulse();
        int base;
        int top;
        int rise;
        int fall;
        int hold;
        base = $urandom_range(0, 300);
        top  = $urandom_range(base, 1023);
        rise = $urandom_range(1, 8);
        fall = $urandom_range(2, 12);
        hold = $urandom_range(1, 10);
        for (int i = 1; i <= rise; i++) begin
            send_sample(clip_sample(base + (top - base) * i / rise
                                    + $urandom_range(0, 4) - 2));
        end
        for (int i = 1; i <= fall; i++) begin
            send_sample(clip_sample(top - (top - base) * i / fall
                                    + $urandom_range(0, 4) - 2));
        end
        for (int i = 0; i < hold; i++) begin
            send_sample(clip_sample(base + $urandom_range(0, 8) - 4));
        end
    endtask

    task automatic send_mixed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            send_pulse();
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) send_sample(10'($urandom));
        end else begin
            // finger lifted: sudden low run can force a peak restart
            repeat ($urandom_range(1, 5)) send_sample(10'($urandom_range(0, 20)));
        end
    endtask

    initial begin
        int gain_tab[N_PHASES];
        int fall_tab[N_PHASES];
        logic [ppd_pkg::SAMPLE_W-1:0] warmup[$];
        int phase_start;

        sb          = new();
        n_sent      = 0;
        n_settings  = 1;
        burst_left  = 0;
        gaps_on     = 1;
        rx_mode     = 1;
        hold_req    = 0;
        n_holds     = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = ppd_pkg::REG_GAIN;
        i_cfg_data  = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: full swing, exact peak repeat, small drops, restarts
        warmup = '{10'd0, 10'd1023, 10'd1023, 10'd1022, 10'd1020, 10'd1019,
                   10'd1023, 10'd1021, 10'd200, 10'd0, 10'd0, 10'd1, 10'd5,
                   10'd512, 10'd511, 10'd400, 10'd399, 10'd1023, 10'd700,
                   10'd1023, 10'd3};
        foreach (warmup[i]) begin
            send_sample(warmup[i]);
        end

        // extremes, zero gain, gain above fall margin, reset values, random
        gain_tab = '{1, 1000, 0, 1023, 400, 50, 0, 0};
        fall_tab = '{3, 3000, 0, 4095, 100, 150, 0, 0};
        gain_tab[6] = $urandom_range(1, 1023);
        fall_tab[6] = $urandom_range(0, 4095);
        gain_tab[7] = $urandom_range(1, 1023);
        fall_tab[7] = $urandom_range(0, 4095);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            load_setting(gain_tab[ph], fall_tab[ph]);
            rx_mode = ph % 4;
            gaps_on = (ph % 3 != 1);
            send_sample(10'd0);
            send_sample(10'd1023);
            send_sample(10'd512);
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_WORDS) begin
                send_mixed();
                if ((ph == 1 || ph == 6) && n_sent - phase_start >= 40 && n_holds == 0
                    && !hold_req) begin
                    hold_req = 1;
                end
                if (ph == 4 && n_sent - phase_start >= 60 && n_sent - phase_start < 80) begin
                    wait_drained();
                    phase_start = phase_start - 20;
                end
            end
        end

        wait_drained();
        $display("%0d samples sent, %0d beat words checked with %0d beats", n_sent,
                 sb.n_checked, sb.n_beats);
        $display("%0d register settings, %0d long output hold-offs", n_settings, n_holds);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("pulse_peak_detector verification clean");
        end else begin
            if (sb.pending() != 0) begin
                $display("%0t: %0d beat words never arrived", $time, sb.pending());
            end
            $display("pulse_peak_detector verification failed");
        end
        $finish;
    end

endmodule
